/* hdl/qte_pkg.sv */
// Shared types, constants and the arctangent table of the quaternion to Euler core.
package qte_pkg;

   localparam int IN_WIDTH         = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int COMP_W           = 16;
   localparam int CW               = 40;
   localparam int ZW               = 33;
   localparam int DIV_BITS         = 30;
   localparam int SQRT_BITS        = 31;
   localparam int ANGLE_W          = 16;

   localparam logic signed [ZW-1:0] PI_Q28          = 33'sd843314857;
   localparam logic signed [26:0]   DEG_PER_RAD_Q20 = 27'sd60078979;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] q_real;
      logic signed [IN_WIDTH-1:0] q_i;
      logic signed [IN_WIDTH-1:0] q_j;
      logic signed [IN_WIDTH-1:0] q_k;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] yaw_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] roll_angle;
      logic                      invalid;
   } rsp_type;

   function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      unique case (idx)
         5'd0:    v = 33'sd210828714;
         5'd1:    v = 33'sd124459457;
         5'd2:    v = 33'sd65760959;
         5'd3:    v = 33'sd33381290;
         5'd4:    v = 33'sd16755422;
         5'd5:    v = 33'sd8385879;
         5'd6:    v = 33'sd4193963;
         5'd7:    v = 33'sd2097109;
         5'd8:    v = 33'sd1048571;
         5'd9:    v = 33'sd524287;
         5'd10:   v = 33'sd262144;
         5'd11:   v = 33'sd131072;
         5'd12:   v = 33'sd65536;
         5'd13:   v = 33'sd32768;
         5'd14:   v = 33'sd16384;
         5'd15:   v = 33'sd8192;
         5'd16:   v = 33'sd4096;
         5'd17:   v = 33'sd2048;
         5'd18:   v = 33'sd1024;
         5'd19:   v = 33'sd512;
         5'd20:   v = 33'sd256;
         5'd21:   v = 33'sd128;
         5'd22:   v = 33'sd64;
         5'd23:   v = 33'sd32;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/qte_cordic.sv */
// Pipelined vectoring CORDIC that returns atan2(y, x) in radians Q4.28.
module qte_cordic #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic signed [qte_pkg::CW-1:0]     y_in,
   input  logic signed [qte_pkg::CW-1:0]     x_in,
   output logic signed [qte_pkg::ZW-1:0]     z_out
);

   logic signed [qte_pkg::CW-1:0] x_ff    [STEPS+1];
   logic signed [qte_pkg::CW-1:0] y_ff    [STEPS+1];
   logic signed [qte_pkg::ZW-1:0] z_ff    [STEPS+1];
   logic                          zero_ff [STEPS+1];

   always_ff @(posedge clock) begin
      zero_ff[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[qte_pkg::CW-1]) begin
         x_ff[0] <= -x_in;
         y_ff[0] <= -y_in;
         z_ff[0] <= y_in[qte_pkg::CW-1] ? -qte_pkg::PI_Q28 : qte_pkg::PI_Q28;
      end else begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (!y_ff[i][qte_pkg::CW-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + qte_pkg::atan_q28(5'(i));
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - qte_pkg::atan_q28(5'(i));
         end
      end
   end

   assign z_out = zero_ff[STEPS] ? '0 : z_ff[STEPS];

endmodule

/* hdl/quaternion_to_euler_core.sv */
// Top level of the quaternion to Euler angle core: products, divider, square root, CORDIC.
// Results come out in the order the transactions were accepted.
// Throughput: one transaction every cycle; busy stays low and the result strobe cannot stall.
// The pipeline holds the 30 divider stages, the 31 square root stages and the CORDIC stages.
// Reset clears the valid bits of every stage and sets degrees_ff to radians.
// Data registers are not reset; a transaction in flight at reset is dropped.
module quaternion_to_euler_core #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qte_pkg::req_type req_data,
   output logic             rsp_valid,
   output qte_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int CW   = qte_pkg::CW;
   localparam int ZW   = qte_pkg::ZW;
   localparam int DB   = qte_pkg::DIV_BITS;
   localparam int SB   = qte_pkg::SQRT_BITS;
   localparam int YRL  = DB + 2 + SB;
   localparam int META = YRL + 1 + CORDIC_STEPS;
   localparam int LAT  = 67 + CORDIC_STEPS;

   logic degrees_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degrees_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         degrees_ff <= csr_data;
      end
   end

   logic signed [15:0] a_in, b_in, c_in, d_in;

   if (qte_pkg::IN_WIDTH >= 16) begin : g_shr
      assign a_in = 16'(req_data.q_real >>> (qte_pkg::IN_WIDTH - 16));
      assign b_in = 16'(req_data.q_i >>> (qte_pkg::IN_WIDTH - 16));
      assign c_in = 16'(req_data.q_j >>> (qte_pkg::IN_WIDTH - 16));
      assign d_in = 16'(req_data.q_k >>> (qte_pkg::IN_WIDTH - 16));
   end else begin : g_shl
      assign a_in = 16'(req_data.q_real) <<< (16 - qte_pkg::IN_WIDTH);
      assign b_in = 16'(req_data.q_i) <<< (16 - qte_pkg::IN_WIDTH);
      assign c_in = 16'(req_data.q_j) <<< (16 - qte_pkg::IN_WIDTH);
      assign d_in = 16'(req_data.q_k) <<< (16 - qte_pkg::IN_WIDTH);
   end

   logic               v1_ff;
   logic signed [31:0] aa_ff, bb_ff, cc_ff, dd_ff;
   logic signed [31:0] bc_ff, da_ff, cd_ff, ba_ff, ac_ff, bd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      aa_ff <= a_in * a_in;
      bb_ff <= b_in * b_in;
      cc_ff <= c_in * c_in;
      dd_ff <= d_in * d_in;
      bc_ff <= b_in * c_in;
      da_ff <= d_in * a_in;
      cd_ff <= c_in * d_in;
      ba_ff <= b_in * a_in;
      ac_ff <= a_in * c_in;
      bd_ff <= b_in * d_in;
   end

   logic signed [33:0] yaw_y_in, yaw_x_in, roll_y_in, roll_x_in, num_in;
   logic        [32:0] den_in, mag_in;

   always_comb begin
      yaw_y_in  = (34'(bc_ff) + 34'(da_ff)) <<< 1;
      yaw_x_in  = 34'(aa_ff) + 34'(bb_ff) - 34'(cc_ff) - 34'(dd_ff);
      roll_y_in = (34'(cd_ff) + 34'(ba_ff)) <<< 1;
      roll_x_in = 34'(aa_ff) - 34'(bb_ff) - 34'(cc_ff) + 34'(dd_ff);
      num_in    = (34'(ac_ff) - 34'(bd_ff)) <<< 1;
      den_in    = 33'(34'(aa_ff) + 34'(bb_ff) + 34'(cc_ff) + 34'(dd_ff));
      mag_in    = num_in[33] ? 33'(-num_in) : 33'(num_in);
   end

   logic        [32:0] den_ff  [DB+1];
   logic        [32:0] rem_ff  [DB+1];
   logic        [DB-1:0] quo_ff [DB+1];
   logic               sat_ff  [DB+1];
   logic               neg_ff  [DB+1];
   logic signed [CW-1:0] yrl_ff [YRL][4];
   logic               mv_ff   [META];
   logic               mz_ff   [META];

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff[0] <= 1'b0;
      end else begin
         mv_ff[0] <= v1_ff;
      end
      mz_ff[0]     <= (den_in == '0);
      den_ff[0]    <= den_in;
      rem_ff[0]    <= mag_in;
      quo_ff[0]    <= '0;
      sat_ff[0]    <= (mag_in >= den_in);
      neg_ff[0]    <= num_in[33];
      yrl_ff[0][0] <= CW'(yaw_y_in);
      yrl_ff[0][1] <= CW'(yaw_x_in);
      yrl_ff[0][2] <= CW'(roll_y_in);
      yrl_ff[0][3] <= CW'(roll_x_in);
   end

   for (genvar m = 1; m < META; m++) begin : g_meta
      always_ff @(posedge clock) begin
         if (reset) begin
            mv_ff[m] <= 1'b0;
         end else begin
            mv_ff[m] <= mv_ff[m-1];
         end
         mz_ff[m] <= mz_ff[m-1];
      end
   end

   for (genvar m = 1; m < YRL; m++) begin : g_yrl
      always_ff @(posedge clock) begin
         yrl_ff[m] <= yrl_ff[m-1];
      end
   end

   for (genvar k = 1; k <= DB; k++) begin : g_div
      logic [33:0] shifted;
      assign shifted = {rem_ff[k-1], 1'b0};
      always_ff @(posedge clock) begin
         den_ff[k] <= den_ff[k-1];
         sat_ff[k] <= sat_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         if (shifted >= 34'(den_ff[k-1])) begin
            rem_ff[k] <= 33'(shifted - 34'(den_ff[k-1]));
            quo_ff[k] <= {quo_ff[k-1][DB-2:0], 1'b1};
         end else begin
            rem_ff[k] <= 33'(shifted);
            quo_ff[k] <= {quo_ff[k-1][DB-2:0], 1'b0};
         end
      end
   end

   logic [SB-1:0] s_div;
   logic [SB-1:0] s_ff;
   logic          sneg_ff;
   logic [61:0]   ss_ff;

   assign s_div = sat_ff[DB] ? (SB'(1) << DB) : SB'(quo_ff[DB]);

   always_ff @(posedge clock) begin
      s_ff    <= s_div;
      sneg_ff <= neg_ff[DB];
      ss_ff   <= s_div * s_div;
   end

   logic [60:0]   srem_ff  [SB+1];
   logic [SB-1:0] root_ff  [SB+1];
   logic [SB-1:0] sval_ff  [SB+1];
   logic          svneg_ff [SB+1];

   always_comb begin
      srem_ff[0]  = 61'((62'(1) << 60) - ss_ff);
      root_ff[0]  = '0;
      sval_ff[0]  = s_ff;
      svneg_ff[0] = sneg_ff;
   end

   for (genvar j = 1; j <= SB; j++) begin : g_sqrt
      localparam int BIT = SB - j;
      logic [61:0] trial;
      assign trial = (62'(root_ff[j-1]) << (BIT + 1)) | (62'(1) << (2 * BIT));
      always_ff @(posedge clock) begin
         sval_ff[j]  <= sval_ff[j-1];
         svneg_ff[j] <= svneg_ff[j-1];
         if (62'(srem_ff[j-1]) >= trial) begin
            srem_ff[j] <= 61'(62'(srem_ff[j-1]) - trial);
            root_ff[j] <= root_ff[j-1] | (SB'(1) << BIT);
         end else begin
            srem_ff[j] <= srem_ff[j-1];
            root_ff[j] <= root_ff[j-1];
         end
      end
   end

   logic signed [CW-1:0] pitch_y, pitch_x;
   logic signed [ZW-1:0] yaw_z, pitch_z, roll_z;

   assign pitch_y = svneg_ff[SB] ? -CW'(sval_ff[SB]) : CW'(sval_ff[SB]);
   assign pitch_x = CW'(root_ff[SB]);

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock),
      .y_in  (yrl_ff[YRL-1][0]),
      .x_in  (yrl_ff[YRL-1][1]),
      .z_out (yaw_z)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock),
      .y_in  (pitch_y),
      .x_in  (pitch_x),
      .z_out (pitch_z)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock),
      .y_in  (yrl_ff[YRL-1][2]),
      .x_in  (yrl_ff[YRL-1][3]),
      .z_out (roll_z)
   );

   logic                 cv_ff, cz_ff;
   logic signed [ZW-1:0] z_ff    [3];
   logic signed [59:0]   prod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else begin
         cv_ff <= mv_ff[META-1];
      end
      cz_ff      <= mz_ff[META-1];
      z_ff[0]    <= yaw_z;
      z_ff[1]    <= pitch_z;
      z_ff[2]    <= roll_z;
      prod_ff[0] <= yaw_z * qte_pkg::DEG_PER_RAD_Q20;
      prod_ff[1] <= pitch_z * qte_pkg::DEG_PER_RAD_Q20;
      prod_ff[2] <= roll_z * qte_pkg::DEG_PER_RAD_Q20;
   end

   function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] z,
                                                 input logic signed [59:0] p,
                                                 input logic deg);
      logic signed [60:0] pr;
      logic signed [ZW:0] zr;
      logic signed [18:0] r;
      pr = 61'(p) + (61'sd1 <<< 41);
      zr = (ZW+1)'(z) + ((ZW+1)'(1) <<< 15);
      r  = deg ? 19'(pr >>> 42) : 19'(zr >>> 16);
      if (r > 19'sd32767) begin
         return 16'sh7fff;
      end else if (r < -19'sd32768) begin
         return 16'sh8000;
      end
      return 16'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cv_ff;
      end
      if (cz_ff) begin
         rsp_data <= '{yaw_angle: '0, pitch_angle: '0, roll_angle: '0, invalid: 1'b1};
      end else begin
         rsp_data.yaw_angle   <= to_out(z_ff[0], prod_ff[0], degrees_ff);
         rsp_data.pitch_angle <= to_out(z_ff[1], prod_ff[1], degrees_ff);
         rsp_data.roll_angle  <= to_out(z_ff[2], prod_ff[2], degrees_ff);
         rsp_data.invalid     <= 1'b0;
      end
   end

`ifndef ASSERT_OFF
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted transaction did not produce a result on time");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.invalid) |->
         (rsp_data.yaw_angle == '0 && rsp_data.pitch_angle == '0 &&
          rsp_data.roll_angle == '0))
      else $error("invalid result carries nonzero angles");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cv_ff))
      else $error("result strobe without a transaction in the last stage");
`endif

endmodule
